[hw/rtl/sme_pkg.sv]
package sme_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RANK_W   = 7;
  localparam int CMP_W    = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [31:0] value;
    logic [RANK_W-1:0] rank;
  } sme_in_t;

  typedef struct packed {
    logic               read_valid;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    logic               overflow;
  } sme_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_RDW,
    ST_FIN
  } sme_state_t;

  typedef struct packed {
    logic load;
    logic ins_step;
    logic rem_step;
    logic rd_cap;
    logic out_load;
  } sme_cmd_t;

  typedef struct packed {
    logic full;
    logic ins_last;
    logic rem_last;
    logic out_free;
  } sme_stat_t;

endpackage

[hw/rtl/sme_ctrl.sv]
module sme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_stall,
  input  sme_pkg::sme_stat_t stat,
  output sme_pkg::sme_cmd_t  cmd
);

  sme_pkg::sme_state_t state_r;
  sme_pkg::sme_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sme_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            sme_pkg::FUNC_INSERT: state_nxt = stat.full ? sme_pkg::ST_FIN : sme_pkg::ST_INS;
            sme_pkg::FUNC_REMOVE: state_nxt = sme_pkg::ST_REM;
            sme_pkg::FUNC_READ:   state_nxt = sme_pkg::ST_RDW;
            default:              state_nxt = sme_pkg::ST_FIN;
          endcase
        end
      end
      sme_pkg::ST_INS: begin
        if (stat.ins_last) state_nxt = sme_pkg::ST_FIN;
      end
      sme_pkg::ST_REM: begin
        if (stat.rem_last) state_nxt = sme_pkg::ST_FIN;
      end
      sme_pkg::ST_RDW: state_nxt = sme_pkg::ST_FIN;
      sme_pkg::ST_FIN: begin
        if (stat.out_free) state_nxt = sme_pkg::ST_IDLE;
      end
      default: state_nxt = sme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      sme_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      sme_pkg::ST_INS: cmd.ins_step = 1'b1;
      sme_pkg::ST_REM: cmd.rem_step = 1'b1;
      sme_pkg::ST_RDW: cmd.rd_cap   = 1'b1;
      sme_pkg::ST_FIN: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/sme_dp.sv]
module sme_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sme_pkg::sme_in_t   in_word,
  input  sme_pkg::sme_cmd_t  cmd,
  output sme_pkg::sme_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output sme_pkg::sme_out_t  out_word
);

  logic signed [31:0] mem [sme_pkg::CAPACITY];
  logic signed [31:0] rdata_r;

  logic [sme_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [sme_pkg::CNT_W-1:0]  i_r, i_nxt;
  logic [sme_pkg::CNT_W-1:0]  rd_r, rd_nxt;
  logic [sme_pkg::CNT_W-1:0]  wr_r, wr_nxt;
  logic signed [31:0]         value_r, value_nxt;
  logic [sme_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic                       res_valid_r, res_valid_nxt;
  logic signed [31:0]         res_value_r, res_value_nxt;
  logic                       res_ovf_r, res_ovf_nxt;
  logic                       out_valid_r;
  sme_pkg::sme_out_t          out_word_r;

  logic                       we;
  logic [sme_pkg::ADDR_W-1:0] waddr;
  logic signed [31:0]         wdata;
  logic [sme_pkg::ADDR_W-1:0] raddr;
  logic                       rank_hit;

  assign stat.full     = (count_r == sme_pkg::CNT_W'(sme_pkg::CAPACITY));
  assign stat.ins_last = (i_r == '0) || !(rdata_r > value_r);
  assign stat.rem_last = (rd_r == count_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign rank_hit = (rank_r != '0) &&
                    (sme_pkg::CMP_W'(rank_r) <= sme_pkg::CMP_W'(count_r));

  always_comb begin
    count_nxt     = count_r;
    i_nxt         = i_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    value_nxt     = value_r;
    rank_nxt      = rank_r;
    res_valid_nxt = res_valid_r;
    res_value_nxt = res_value_r;
    res_ovf_nxt   = res_ovf_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = rdata_r;
    raddr         = '0;

    if (cmd.load) begin
      value_nxt     = in_word.value;
      rank_nxt      = in_word.rank;
      res_valid_nxt = 1'b0;
      res_value_nxt = '0;
      res_ovf_nxt   = (in_word.func == sme_pkg::FUNC_INSERT) && stat.full;
      i_nxt         = count_r;
      rd_nxt        = '0;
      wr_nxt        = '0;
      unique case (in_word.func)
        sme_pkg::FUNC_INSERT: raddr = sme_pkg::ADDR_W'(count_r - 1'b1);
        sme_pkg::FUNC_READ:   raddr = sme_pkg::ADDR_W'(in_word.rank - 1'b1);
        default:              raddr = '0;
      endcase
    end

    // walk down from the top, moving larger entries up one slot
    if (cmd.ins_step) begin
      we    = 1'b1;
      waddr = sme_pkg::ADDR_W'(i_r);
      if (stat.ins_last) begin
        wdata     = value_r;
        count_nxt = count_r + 1'b1;
      end else begin
        wdata = rdata_r;
        i_nxt = i_r - 1'b1;
        raddr = sme_pkg::ADDR_W'(i_r - 2'd2);
      end
    end

    // compact: copy every entry that does not match down to the write index
    if (cmd.rem_step) begin
      if (stat.rem_last) begin
        count_nxt = wr_r;
      end else begin
        if (rdata_r != value_r) begin
          we     = 1'b1;
          waddr  = sme_pkg::ADDR_W'(wr_r);
          wdata  = rdata_r;
          wr_nxt = wr_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
        raddr  = sme_pkg::ADDR_W'(rd_r + 1'b1);
      end
    end

    if (cmd.rd_cap) begin
      res_valid_nxt = rank_hit;
      res_value_nxt = rank_hit ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    rd_r        <= rd_nxt;
    wr_r        <= wr_nxt;
    value_r     <= value_nxt;
    rank_r      <= rank_nxt;
    res_valid_r <= res_valid_nxt;
    res_value_r <= res_value_nxt;
    res_ovf_r   <= res_ovf_nxt;
    if (cmd.out_load) begin
      out_word_r.read_valid  <= res_valid_r;
      out_word_r.read_value  <= res_value_r;
      out_word_r.entry_count <= 7'(count_r);
      out_word_r.overflow    <= res_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[hw/rtl/sorted_multiset_engine_unit.sv]
// Each word goes from accept through its operation (insert walk, remove compaction or read) to the result
// word; an overflowed insert and an unused code go straight to the result word.
// Words are taken one at a time; the walk over the store must finish before the next word is accepted.
// A waiting result word does not block the next accept.
// Reset (rst_n, synchronous, active low) empties the store by clearing the entry count;
// the store contents are not cleared.
module sorted_multiset_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sme_pkg::sme_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output sme_pkg::sme_out_t out_word
);

  sme_pkg::sme_cmd_t  cmd;
  sme_pkg::sme_stat_t stat;

  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_word.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sme_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
